/* rtl/nlej_pkg.sv */
// Shared types and constants for the nested-loop equi-join block.
// No dependencies; used by nlej_cell and nested_loop_equi_join.
package nlej_pkg;

  localparam int RIGHT_DEPTH = 64;
  localparam int KEY_W       = 31;
  localparam int VAL_W       = 32;
  localparam int CNT_W       = $clog2(RIGHT_DEPTH + 1);

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_PROBE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // probe token travelling down the cell row
  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
  } tok_t;

  // match report of one cell, zero when no match
  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } hit_t;

endpackage

/* rtl/nlej_cell.sv */
// One compare cell: holds a stored right tuple and one probe token slot.
// Depends on nlej_pkg.
module nlej_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     live,
  input  logic                     wr_en,
  input  logic [nlej_pkg::KEY_W-1:0] wr_key,
  input  logic [nlej_pkg::VAL_W-1:0] wr_value,
  input  nlej_pkg::tok_t           tok_in,
  output nlej_pkg::tok_t           tok_out,
  output nlej_pkg::hit_t           hit
);

  logic [nlej_pkg::KEY_W-1:0] key_r;
  logic [nlej_pkg::VAL_W-1:0] value_r;
  logic                       tok_valid_r;
  logic [nlej_pkg::VAL_W-1:0] tok_value_r;
  logic                       match;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r   <= wr_key;
      value_r <= wr_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_value_r <= tok_in.value;
  end

  assign match = tok_valid_r && live && (tok_value_r == value_r);

  // drop the token past the last filled cell
  assign tok_out.valid = tok_valid_r && live;
  assign tok_out.value = tok_value_r;

  assign hit.hit   = match;
  assign hit.key   = match ? key_r : '0;
  assign hit.value = match ? value_r : '0;

endmodule

/* rtl/nested_loop_equi_join.sv */
// Nested-loop equi-join over one partition: a row of compare cells plus control.
// Depends on nlej_pkg and nlej_cell.
// Clear, load, ignored items and probes of an empty store are taken while idle; busy stays low.
// A probe on a store of N tuples holds busy while its token walks the cell row
// one cell per cycle, and then through the flush state, which releases the final match.
// Each match is held until the next match (or the flush) releases it and shows in
// the cycle after that; the last result shows in the first cycle after busy drops.
// Reset (rst_n low, synchronous) empties the store and clears the overflow flag.
module nested_loop_equi_join (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_start,
  output logic                         busy,
  input  logic [1:0]                   in_mode,
  input  logic [nlej_pkg::KEY_W-1:0]   in_tuple_key,
  input  logic [nlej_pkg::VAL_W-1:0]   in_tuple_value,
  output logic                         out_valid,
  output logic [nlej_pkg::KEY_W-1:0]   out_right_key,
  output logic [nlej_pkg::VAL_W-1:0]   out_right_value,
  output logic [nlej_pkg::KEY_W-1:0]   out_left_key,
  output logic [nlej_pkg::VAL_W-1:0]   out_left_value,
  output logic                         out_last_match,
  output logic                         out_store_overflowed
);

  localparam int DEPTH = nlej_pkg::RIGHT_DEPTH;
  localparam int CW    = nlej_pkg::CNT_W;

  nlej_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic [nlej_pkg::KEY_W-1:0] lkey_r, lkey_nxt;
  logic [nlej_pkg::VAL_W-1:0] lval_r, lval_nxt;

  // one match held back until we know whether it is the last
  logic                       pend_valid_r, pend_valid_nxt;
  logic [nlej_pkg::KEY_W-1:0] pend_key_r, pend_key_nxt;
  logic [nlej_pkg::VAL_W-1:0] pend_val_r, pend_val_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [nlej_pkg::KEY_W-1:0] out_rkey_r, out_rkey_nxt;
  logic [nlej_pkg::VAL_W-1:0] out_rval_r, out_rval_nxt;
  logic [nlej_pkg::KEY_W-1:0] out_lkey_r, out_lkey_nxt;
  logic [nlej_pkg::VAL_W-1:0] out_lval_r, out_lval_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic           accept;
  logic           load_en;
  nlej_pkg::tok_t tok_head;
  nlej_pkg::tok_t tok_chain [DEPTH+1];
  nlej_pkg::hit_t hits [DEPTH];
  nlej_pkg::hit_t hit_any;

  assign busy   = (state_r != nlej_pkg::ST_IDLE);
  assign accept = in_start && !busy;

  // write goes to the first empty cell; a full store drops it
  assign load_en = accept && (in_mode == nlej_pkg::MODE_LOAD) && (count_r < CW'(DEPTH));

  // inject the probe token at the head of the row
  assign tok_head.valid = accept && (in_mode == nlej_pkg::MODE_PROBE) && (count_r != '0);
  assign tok_head.value = in_tuple_value;
  assign tok_chain[0]   = tok_head;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    nlej_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .live     (count_r > CW'(j)),
      .wr_en    (load_en && (count_r == CW'(j))),
      .wr_key   (in_tuple_key),
      .wr_value (in_tuple_value),
      .tok_in   (tok_chain[j]),
      .tok_out  (tok_chain[j+1]),
      .hit      (hits[j])
    );
  end

  // only the cell holding the token can report, so an OR picks its tuple
  always_comb begin
    hit_any = '0;
    for (int j = 0; j < DEPTH; j++) begin
      hit_any = hit_any | hits[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nlej_pkg::ST_IDLE;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    lkey_r     <= lkey_nxt;
    lval_r     <= lval_nxt;
    pend_key_r <= pend_key_nxt;
    pend_val_r <= pend_val_nxt;
    out_rkey_r <= out_rkey_nxt;
    out_rval_r <= out_rval_nxt;
    out_lkey_r <= out_lkey_nxt;
    out_lval_r <= out_lval_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    ovf_nxt        = ovf_r;
    lkey_nxt       = lkey_r;
    lval_nxt       = lval_r;
    pend_valid_nxt = pend_valid_r;
    pend_key_nxt   = pend_key_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = 1'b0;
    out_rkey_nxt   = out_rkey_r;
    out_rval_nxt   = out_rval_r;
    out_lkey_nxt   = out_lkey_r;
    out_lval_nxt   = out_lval_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;

    unique case (state_r)
      nlej_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            nlej_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
            end
            nlej_pkg::MODE_LOAD: begin
              if (count_r < CW'(DEPTH)) begin
                count_nxt = count_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            nlej_pkg::MODE_PROBE: begin
              lkey_nxt = in_tuple_key;
              lval_nxt = in_tuple_value;
              // an empty store answers nothing; stay idle
              if (count_r != '0) begin
                pos_nxt   = '0;
                state_nxt = nlej_pkg::ST_SCAN;
              end
            end
            default: begin
              // unused mode: ignore the item
            end
          endcase
        end
      end

      nlej_pkg::ST_SCAN: begin
        if (hit_any.hit) begin
          // a newer match exists, so release the held one as not last
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_rkey_nxt  = pend_key_r;
            out_rval_nxt  = pend_val_r;
            out_lkey_nxt  = lkey_r;
            out_lval_nxt  = lval_r;
            out_last_nxt  = 1'b0;
            out_ovf_nxt   = ovf_r;
          end
          pend_valid_nxt = 1'b1;
          pend_key_nxt   = hit_any.key;
          pend_val_nxt   = hit_any.value;
        end
        pos_nxt = pos_r + CW'(1);
        if (pos_r == count_r - CW'(1)) begin
          state_nxt = nlej_pkg::ST_FLUSH;
        end
      end

      nlej_pkg::ST_FLUSH: begin
        // scan done: whatever is held is the final match
        if (pend_valid_r) begin
          out_valid_nxt = 1'b1;
          out_rkey_nxt  = pend_key_r;
          out_rval_nxt  = pend_val_r;
          out_lkey_nxt  = lkey_r;
          out_lval_nxt  = lval_r;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = ovf_r;
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = nlej_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = nlej_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_right_key        = out_rkey_r;
  assign out_right_value      = out_rval_r;
  assign out_left_key         = out_lkey_r;
  assign out_left_value       = out_lval_r;
  assign out_last_match       = out_last_r;
  assign out_store_overflowed = out_ovf_r;

endmodule
